### hw/rtl/pfcc_pkg.sv
// Package: payload types and frame layout constants for the frame checksum checker.
`timescale 1ns / 1ps

package pfcc_pkg;

   localparam int unsigned POS_WIDTH = 9;

   localparam logic [POS_WIDTH-1:0] POS_ID          = 9'd0;
   localparam logic [POS_WIDTH-1:0] POS_LENGTH      = 9'd1;
   localparam logic [POS_WIDTH-1:0] POS_STAMP_FIRST = 9'd2;
   localparam logic [POS_WIDTH-1:0] POS_SUM_LOW     = 9'd6;
   localparam logic [POS_WIDTH-1:0] POS_SUM_HIGH    = 9'd7;
   localparam logic [POS_WIDTH-1:0] HEADER_LAST     = 9'd7;

   localparam int unsigned STAMP_BYTES = 4;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       start_of_frame;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  packet_id;
      logic [7:0]  data_length;
      logic [31:0] time_stamp;
      logic [15:0] computed_sum;
      logic        checksum_ok;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      req_payload_type payload;
   } stage_type;

endpackage

### hw/rtl/pfcc_stream_if.sv
// Interface: valid/ready stream channel carrying one payload.
`timescale 1ns / 1ps

interface pfcc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/packet_frame_checksum_checker.sv
// An accepted request moves through the input register and then the response register.
// Throughput: one request per cycle; the input register and the response
// register stall together while a response waits for rsp ready.
// Reset: synchronous, clears the pipeline valid bits and returns the frame
// position to waiting for an id byte.
`timescale 1ns / 1ps

module packet_frame_checksum_checker (
   input  logic          clock,
   input  logic          reset,
   pfcc_stream_if.sink   req_if,
   pfcc_stream_if.source rsp_if
);
   import pfcc_pkg::*;

   stage_type stage;
   logic      advance;

   pfcc_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req_if  (req_if),
      .stage   (stage)
   );

   pfcc_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .advance (advance),
      .rsp_if  (rsp_if)
   );

endmodule

### hw/rtl/pfcc_in_stage.sv
// Input register stage: captures one request per cycle while advance is high or the register is empty.
`timescale 1ns / 1ps

module pfcc_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   pfcc_stream_if.sink          req_if,
   output pfcc_pkg::stage_type  stage
);
   import pfcc_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   req_payload_type payload_ff;
   logic            take;

   assign req_if.ready = advance || !valid_ff;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_if.ready) begin
         valid_in = req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         payload_ff <= req_if.payload;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.payload = payload_ff;

endmodule

### hw/rtl/pfcc_accum.sv
// Frame tracker: running sums, header capture and response register.
`timescale 1ns / 1ps

module pfcc_accum (
   input  logic                 clock,
   input  logic                 reset,
   input  pfcc_pkg::stage_type  stage,
   output logic                 advance,
   pfcc_stream_if.source        rsp_if
);
   import pfcc_pkg::*;

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0]           low_ff, low_in;
   logic [7:0]           high_ff, high_in;
   logic [7:0]           id_ff, id_in;
   logic [7:0]           length_ff, length_in;
   logic [31:0]          stamp_ff, stamp_in;
   logic [15:0]          recv_ff, recv_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_ff, rsp_in;

   logic [POS_WIDTH-1:0] pos;
   logic [7:0]           b;
   logic [7:0]           low_base, high_base, low_sum, high_sum;
   logic                 summed;
   logic                 done;
   logic                 step;

   assign advance = !rsp_valid_ff || rsp_if.ready;
   assign step    = advance && stage.valid;
   assign b       = stage.payload.frame_byte;

   always_comb begin
      pos       = stage.payload.start_of_frame ? POS_ID : pos_ff;
      low_base  = (pos == POS_ID) ? 8'd0 : low_ff;
      high_base = (pos == POS_ID) ? 8'd0 : high_ff;
      summed    = (pos != POS_SUM_LOW) && (pos != POS_SUM_HIGH);
      low_sum   = low_base + b;
      high_sum  = high_base + low_sum;
      low_in    = summed ? low_sum : low_base;
      high_in   = summed ? high_sum : high_base;

      id_in     = (pos == POS_ID) ? b : id_ff;
      length_in = length_ff;
      stamp_in  = stamp_ff;
      recv_in   = recv_ff;
      if (pos == POS_ID) begin
         length_in = 8'd0;
         stamp_in  = 32'd0;
         recv_in   = 16'd0;
      end else if (pos == POS_LENGTH) begin
         length_in = b;
      end else if (pos == POS_SUM_LOW) begin
         recv_in[7:0] = b;
      end else if (pos == POS_SUM_HIGH) begin
         recv_in[15:8] = b;
      end
      for (int i = 0; i < STAMP_BYTES; i++) begin
         if (pos == POS_STAMP_FIRST + POS_WIDTH'(i)) begin
            stamp_in[8*i +: 8] = b;
         end
      end

      done   = (pos >= HEADER_LAST) && (pos == HEADER_LAST + {1'b0, length_in});
      pos_in = done ? POS_ID : pos + 9'd1;

      rsp_in.packet_id    = id_in;
      rsp_in.data_length  = length_in;
      rsp_in.time_stamp   = stamp_in;
      rsp_in.computed_sum = {high_in, low_in};
      rsp_in.checksum_ok  = ({high_in, low_in} == recv_in);

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = stage.valid && done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_ID;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         low_ff    <= low_in;
         high_ff   <= high_in;
         id_ff     <= id_in;
         length_ff <= length_in;
         stamp_ff  <= stamp_in;
         recv_ff   <= recv_in;
         rsp_ff    <= rsp_in;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

endmodule

### tb/sv/tb_packet_frame_checksum_checker.sv
// Testbench: directed and random framed byte traffic checked against a running Fletcher-style mod-256 frame predictor.
`timescale 1ns / 1ps

module tb_packet_frame_checksum_checker;
   import pfcc_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 150;
   localparam int TARGET_BYTES = 1300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic            src_valid = 1'b0;
   req_payload_type src_payload = '0;
   logic            sink_ready = 1'b0;

   pfcc_stream_if #(.payload_type(req_payload_type)) req_if ();
   pfcc_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   assign req_if.valid = src_valid;
   assign req_if.payload = src_payload;
   assign rsp_if.ready = sink_ready;

   packet_frame_checksum_checker dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #10 clock = ~clock;

   req_payload_type wire_bytes[$];
   rsp_payload_type expected_frames[$];

   logic [8:0]  frame_pos = POS_ID;
   logic [15:0] run_sums = '0;
   logic [7:0]  held_id = '0;
   logic [7:0]  held_length = '0;
   logic [31:0] held_stamp = '0;
   logic [15:0] rx_sum = '0;

   int req_count = 0;
   int mismatches = 0;
   int stall_cycles = 0;
   int hold_left = 0;
   int holds_done = 0;

   function automatic logic [15:0] fletcher_add(input logic [15:0] sums, input logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = sums[7:0] + b;
      hi = sums[15:8] + lo;
      return {hi, lo};
   endfunction

   task automatic predict_frame_byte(input req_payload_type r);
      logic [8:0]      pos;
      rsp_payload_type res;
      pos = r.start_of_frame ? POS_ID : frame_pos;
      if (pos == POS_ID) begin
         run_sums = fletcher_add(16'h0000, r.frame_byte);
         held_id = r.frame_byte;
         held_length = '0;
         held_stamp = '0;
         rx_sum = '0;
      end else if (pos == POS_LENGTH) begin
         held_length = r.frame_byte;
         run_sums = fletcher_add(run_sums, r.frame_byte);
      end else if (pos < POS_SUM_LOW) begin
         held_stamp[(pos - POS_STAMP_FIRST) * 8 +: 8] = r.frame_byte;
         run_sums = fletcher_add(run_sums, r.frame_byte);
      end else if (pos == POS_SUM_LOW) begin
         rx_sum[7:0] = r.frame_byte;
      end else if (pos == POS_SUM_HIGH) begin
         rx_sum[15:8] = r.frame_byte;
      end else begin
         run_sums = fletcher_add(run_sums, r.frame_byte);
      end
      if (pos >= HEADER_LAST && pos == HEADER_LAST + {1'b0, held_length}) begin
         res.packet_id = held_id;
         res.data_length = held_length;
         res.time_stamp = held_stamp;
         res.computed_sum = run_sums;
         res.checksum_ok = (run_sums == rx_sum);
         expected_frames.push_back(res);
         frame_pos = POS_ID;
      end else begin
         frame_pos = pos + 9'd1;
      end
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %0s: expected %h, got %h at %0t", what, want, got, $time);
   endtask

   task automatic check_frame_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_frames.size() == 0) begin
         note_mismatch("unexpected response, packet_id", '0, 32'(got.packet_id));
      end else begin
         want = expected_frames.pop_front();
         if (got.packet_id !== want.packet_id)
            note_mismatch("packet_id", 32'(want.packet_id), 32'(got.packet_id));
         if (got.data_length !== want.data_length)
            note_mismatch("data_length", 32'(want.data_length), 32'(got.data_length));
         if (got.time_stamp !== want.time_stamp)
            note_mismatch("time_stamp", want.time_stamp, got.time_stamp);
         if (got.computed_sum !== want.computed_sum)
            note_mismatch("computed_sum", 32'(want.computed_sum), 32'(got.computed_sum));
         if (got.checksum_ok !== want.checksum_ok)
            note_mismatch("checksum_ok", 32'(want.checksum_ok), 32'(got.checksum_ok));
      end
   endtask

   // keep < 0 sends the whole frame, otherwise only its first keep bytes
   task automatic add_frame(input bit flag_id, input logic [7:0] id, input logic [7:0] length,
                            input logic [31:0] stamp, input bit bad_sum, input int keep);
      logic [7:0]      body[$];
      logic [15:0]     sums;
      req_payload_type item;
      int              n;
      body = {id, length, stamp[7:0], stamp[15:8], stamp[23:16], stamp[31:24]};
      for (int i = 0; i < length; i++)
         body.push_back(8'($urandom_range(255)));
      sums = '0;
      foreach (body[i])
         sums = fletcher_add(sums, body[i]);
      if (bad_sum)
         sums = sums ^ (16'h0001 << $urandom_range(15));
      body.insert(6, sums[7:0]);
      body.insert(7, sums[15:8]);
      n = (keep < 0 || keep > body.size()) ? body.size() : keep;
      for (int i = 0; i < n; i++) begin
         item.frame_byte = body[i];
         item.start_of_frame = (i == 0) && flag_id;
         wire_bytes.push_back(item);
      end
   endtask

   task automatic build_traffic();
      bit              in_sync;
      int              pick;
      int              size_pick;
      logic [7:0]      length;
      req_payload_type item;
      // unflagged id while waiting, resync mid-stamp, empty frame with bad sum
      add_frame(1'b0, 8'h00, 8'd1, 32'h0000_0000, 1'b0, -1);
      add_frame(1'b1, 8'hFF, 8'd200, 32'hFFFF_FFFF, 1'b0, 4);
      add_frame(1'b1, 8'hFF, 8'd0, 32'hFFFF_FFFF, 1'b1, -1);
      in_sync = 1'b1;
      while (wire_bytes.size() < TARGET_BYTES) begin
         pick = $urandom_range(99);
         size_pick = $urandom_range(199);
         if (size_pick < 3)
            length = 8'd255;
         else if (size_pick < 9)
            length = 8'($urandom_range(254, 13));
         else
            length = 8'($urandom_range(12));
         if (pick < 8) begin
            repeat ($urandom_range(6, 1)) begin
               item.frame_byte = 8'($urandom_range(255));
               item.start_of_frame = 1'($urandom_range(1));
               wire_bytes.push_back(item);
            end
            in_sync = 1'b0;
         end else if (pick < 16) begin
            add_frame(1'b1, 8'($urandom), length, $urandom, 1'($urandom_range(1)),
                      $urandom_range(length + 7, 1));
            in_sync = 1'b0;
         end else begin
            add_frame(!in_sync || ($urandom_range(3) != 0), 8'($urandom), length, $urandom,
                      1'($urandom_range(1)), -1);
            in_sync = 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         src_valid <= 1'b0;
      end else begin
         if (src_valid && req_if.ready) begin
            predict_frame_byte(src_payload);
            req_count <= req_count + 1;
         end
         if (!src_valid || req_if.ready) begin
            if (wire_bytes.size() != 0 &&
                ((req_count >= 500 && req_count < 800) || $urandom_range(99) >= 19)) begin
               src_valid <= 1'b1;
               src_payload <= wire_bytes.pop_front();
            end else begin
               src_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         sink_ready <= 1'b0;
      end else if (hold_left != 0) begin
         sink_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if ((holds_done == 0 && req_count >= 250) ||
                   (holds_done == 1 && req_count >= 900)) begin
         sink_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end else if (req_count >= 500 && req_count < 800) begin
         sink_ready <= 1'b1;
      end else begin
         sink_ready <= ($urandom_range(99) >= 19);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && sink_ready)
         check_frame_result(rsp_if.payload);
   end

   always @(posedge clock) begin
      if (reset || (src_valid && req_if.ready) || (rsp_if.valid && sink_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      build_traffic();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (wire_bytes.size() != 0 || src_valid)
         @(posedge clock);
      while (expected_frames.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
